### src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

### src/cpnl_pkg.sv
// Types and constants for the closest point on normal line block.
package cpnl_pkg;
    localparam int UNIT_BITS = 28;
    localparam int R_LIMIT_BITS = 34;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NEAR_PAR = 2'd1,
        ST_SMALL    = 2'd2,
        ST_PARALLEL = 2'd3
    } t_status;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] near_x;
        logic signed [31:0] near_y;
        logic signed [31:0] near_z;
        logic signed [31:0] far_x;
        logic signed [31:0] far_y;
        logic signed [31:0] far_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [1:0]         status;
    } t_out_word;

    function automatic logic [31:0] sat32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) return 32'h7fffffff;
        if (v < -96'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [95:0] asr28(input logic signed [95:0] v);
        return v >>> UNIT_BITS;
    endfunction
endpackage

### src/cpnl_norm.sv
// Pipelined vector normaliser: align, square-sum, bit-serial root, divide.
module cpnl_norm import cpnl_pkg::*; #(
    parameter int TAGW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic signed [32:0]    i_v [3],
    input  logic [TAGW-1:0]       i_tag,
    output logic                  o_valid,
    output logic signed [31:0]    o_u [3],
    output logic [TAGW-1:0]       o_tag
);
    // stages: 0 align, 1 square sum, 2..33 root (one result bit per stage),
    // 34..64 divide (two quotient bits per stage)
    localparam int RS = 32;
    localparam int DS = 31;
    localparam int NST = 1 + RS + DS;

    logic              r_v   [NST+1];
    logic [TAGW-1:0]   r_tag [NST+1];
    logic [2:0]        r_neg [NST+1];
    logic [31:0]       r_m   [NST+1][3];
    logic [63:0]       r_rem [NST+1];
    logic [63:0]       r_root[NST+1];
    logic [62:0]       r_q   [NST+1][3];
    logic [63:0]       r_dr  [NST+1][3];

    logic [32:0] mag [3];
    logic [32:0] mx;
    logic [5:0]  lz;
    logic [31:0] am [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = i_v[i][32] ? 33'(-i_v[i]) : 33'(i_v[i]);
        end
        mx = mag[0] | mag[1] | mag[2];
        lz = 6'd0;
        for (int b = 0; b < 33; b++) begin
            if (mx[b]) lz = 6'(b);
        end
        // bring the top bit to position 29
        for (int i = 0; i < 3; i++) begin
            if (lz >= 6'd29) am[i] = 32'(mag[i] >> (lz - 6'd29));
            else am[i] = 32'(mag[i] << (6'd29 - lz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NST; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NST; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        for (int i = 0; i < 3; i++) begin
            r_neg[0][i] <= i_v[i][32];
            r_m[0][i] <= (mx == 33'd0) ? 32'd0 : am[i];
        end
        // square sum
        r_tag[1] <= r_tag[0];
        r_neg[1] <= r_neg[0];
        for (int i = 0; i < 3; i++) r_m[1][i] <= r_m[0][i];
        r_rem[1] <= r_m[0][0] * r_m[0][0] + r_m[0][1] * r_m[0][1]
                  + r_m[0][2] * r_m[0][2];
        r_root[1] <= 64'd0;
        // restoring root, one result bit per stage
        for (int s = 2; s < 2 + RS; s++) begin
            logic [63:0] bitv;
            logic [63:0] t;
            bitv = 64'd1 << (2 * (2 + RS - 1 - s));
            t = r_root[s-1] + bitv;
            r_tag[s] <= r_tag[s-1];
            r_neg[s] <= r_neg[s-1];
            for (int i = 0; i < 3; i++) r_m[s][i] <= r_m[s-1][i];
            if (r_rem[s-1] >= t) begin
                r_rem[s] <= r_rem[s-1] - t;
                r_root[s] <= (r_root[s-1] >> 1) + bitv;
            end else begin
                r_rem[s] <= r_rem[s-1];
                r_root[s] <= r_root[s-1] >> 1;
            end
        end
        // long division of m<<28 by length, two quotient bits per stage
        for (int s = 2 + RS; s <= NST; s++) begin
            r_tag[s] <= r_tag[s-1];
            r_neg[s] <= r_neg[s-1];
            r_root[s] <= r_root[s-1];
            for (int i = 0; i < 3; i++) begin
                logic [63:0] rr;
                logic [62:0] qq;
                logic [63:0] num;
                num = 64'(r_m[s-1][i]) << UNIT_BITS;
                if (s == 2 + RS) begin
                    rr = 64'd0;
                    qq = 63'd0;
                end else begin
                    rr = r_dr[s-1][i];
                    qq = r_q[s-1][i];
                end
                for (int k = 0; k < 2; k++) begin
                    int bi;
                    bi = 61 - 2 * (s - 2 - RS) - k;
                    rr = {rr[62:0], (bi >= 0) ? num[bi] : 1'b0};
                    qq = {qq[61:0], 1'b0};
                    if (r_root[s-1] != 64'd0 && rr >= r_root[s-1]) begin
                        rr = rr - r_root[s-1];
                        qq[0] = 1'b1;
                    end
                end
                r_m[s][i] <= r_m[s-1][i];
                r_dr[s][i] <= rr;
                r_q[s][i] <= qq;
            end
        end
    end

    assign o_valid = r_v[NST];
    assign o_tag = r_tag[NST];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_u[i] = r_neg[NST][i] ? -$signed(r_q[NST][i][31:0]) : $signed(r_q[NST][i][31:0]);
        end
    end
endmodule

### src/cpnl_solve.sv
// Dot, cross, status, quotient and final point, in register stages.
module cpnl_solve import cpnl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_u1 [3],
    input  logic signed [31:0] i_u2 [3],
    input  logic signed [31:0] i_c [3],
    input  logic signed [32:0] i_d [3],
    input  logic [15:0]        i_eps,
    output logic               o_valid,
    output t_out_word          o_word
);
    localparam int QS = 46;
    localparam int NST = 5 + QS;

    logic                r_v [NST+1];
    logic signed [31:0]  r_c [NST+1][3];
    logic signed [31:0]  r_u1[NST+1][3];
    logic [1:0]          r_st[NST+1];
    logic signed [95:0]  r_p [3][7];
    logic signed [31:0]  r_b1, r_a1, r_b2;
    logic signed [35:0]  r_c1, r_c2;
    logic signed [95:0]  r_x [3];
    logic signed [95:0]  r_num, r_den;
    logic                r_ng [NST+1];
    logic [63:0]         r_n  [NST+1];
    logic [63:0]         r_dd [NST+1];
    logic [64:0]         r_rm [NST+1];
    logic [35:0]         r_q  [NST+1];
    logic signed [95:0]  r_tm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NST; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NST; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [95:0] epsq;
        logic st1, st2;
        logic signed [95:0] one;
        epsq = 96'(i_eps) <<< (UNIT_BITS - FRAC_BITS);
        one = 96'sd1 <<< UNIT_BITS;
        // stage 0: products
        for (int i = 0; i < 3; i++) begin
            r_c[0][i] <= i_c[i];
            r_u1[0][i] <= i_u1[i];
            r_p[i][0] <= i_u1[i] * i_u1[i];
            r_p[i][1] <= i_u1[i] * i_u2[i];
            r_p[i][2] <= i_u2[i] * i_u2[i];
            r_p[i][3] <= i_u1[i] * i_d[i];
            r_p[i][4] <= i_u2[i] * i_d[i];
            r_p[i][5] <= i_u1[(i+1)%3] * i_u2[(i+2)%3];
            r_p[i][6] <= i_u1[(i+2)%3] * i_u2[(i+1)%3];
        end
        // stage 1: sums
        for (int i = 0; i < 3; i++) begin
            r_c[1][i] <= r_c[0][i];
            r_u1[1][i] <= r_u1[0][i];
            r_x[i] <= asr28(r_p[i][5] - r_p[i][6]);
        end
        r_a1 <= 32'(asr28(r_p[0][0] + r_p[1][0] + r_p[2][0]));
        r_b1 <= 32'(asr28(r_p[0][1] + r_p[1][1] + r_p[2][1]));
        r_b2 <= 32'(asr28(r_p[0][2] + r_p[1][2] + r_p[2][2]));
        r_c1 <= 36'(asr28(r_p[0][3] + r_p[1][3] + r_p[2][3]));
        r_c2 <= 36'(asr28(r_p[0][4] + r_p[1][4] + r_p[2][4]));
        // stage 2: num, den, status
        for (int i = 0; i < 3; i++) begin
            r_c[2][i] <= r_c[1][i];
            r_u1[2][i] <= r_u1[1][i];
        end
        r_num <= r_b1 * r_c2 - r_b2 * r_c1;
        r_den <= r_b1 * r_b1 - r_a1 * r_b2;
        st1 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (r_x[i] > epsq || r_x[i] < -epsq) st1 = 1'b0;
        end
        st2 = (r_b1 <= epsq && r_b1 >= -epsq);
        if (st1) r_st[2] <= ST_NEAR_PAR;
        else if (st2) r_st[2] <= ST_SMALL;
        else if (r_b1 == one || r_b1 == -one) r_st[2] <= ST_PARALLEL;
        else r_st[2] <= ST_OK;
        // stage 3: magnitudes
        for (int i = 0; i < 3; i++) begin
            r_c[3][i] <= r_c[2][i];
            r_u1[3][i] <= r_u1[2][i];
        end
        r_st[3] <= (r_st[2] == ST_OK && r_den == 96'sd0) ? ST_PARALLEL : r_st[2];
        r_ng[3] <= r_num[95] ^ r_den[95];
        r_n[3] <= r_num[95] ? 64'(-r_num) : 64'(r_num);
        r_dd[3] <= r_den[95] ? 64'(-r_den) : 64'(r_den);
        r_rm[3] <= 65'd0;
        r_q[3] <= 36'd0;
        // quotient, two bits per stage over the 92-bit dividend |num| << 28
        for (int s = 4; s < 4 + QS; s++) begin
            logic [64:0] rr;
            logic [35:0] qq;
            rr = r_rm[s-1];
            qq = r_q[s-1];
            for (int k = 0; k < 2; k++) begin
                int bi;
                bi = 91 - 2 * (s - 4) - k;
                if (bi >= 0) begin
                    rr = {rr[63:0], (bi >= UNIT_BITS) ? r_n[s-1][bi-UNIT_BITS] : 1'b0};
                    if (qq[35:34] != 2'b00) qq = 36'd1 << R_LIMIT_BITS;
                    else begin
                        qq = {qq[34:0], 1'b0};
                        if (r_dd[s-1] != 64'd0 && rr >= 65'(r_dd[s-1])) begin
                            rr = rr - 65'(r_dd[s-1]);
                            qq[0] = 1'b1;
                        end
                    end
                end
            end
            if (qq > (36'd1 << R_LIMIT_BITS)) qq = 36'd1 << R_LIMIT_BITS;
            r_rm[s] <= rr;
            r_q[s] <= qq;
            r_n[s] <= r_n[s-1];
            r_dd[s] <= r_dd[s-1];
            r_ng[s] <= r_ng[s-1];
            r_st[s] <= r_st[s-1];
            for (int i = 0; i < 3; i++) begin
                r_c[s][i] <= r_c[s-1][i];
                r_u1[s][i] <= r_u1[s-1][i];
            end
        end
        // terms
        for (int i = 0; i < 3; i++) begin
            logic signed [36:0] r1;
            logic signed [95:0] pr;
            r1 = r_ng[3+QS] ? -$signed({1'b0, r_q[3+QS]}) : $signed({1'b0, r_q[3+QS]});
            pr = r_u1[3+QS][i] * r1;
            r_tm[i] <= asr28(pr);
            r_c[4+QS][i] <= r_c[3+QS][i];
        end
        r_st[4+QS] <= r_st[3+QS];
        // output
        if (r_st[4+QS] != ST_OK) begin
            o_word.point_x <= r_c[4+QS][0];
            o_word.point_y <= r_c[4+QS][1];
            o_word.point_z <= r_c[4+QS][2];
            o_word.offset_x <= 32'sd0;
            o_word.offset_y <= 32'sd0;
            o_word.offset_z <= 32'sd0;
        end else begin
            o_word.point_x <= sat32(96'(r_c[4+QS][0]) + r_tm[0]);
            o_word.point_y <= sat32(96'(r_c[4+QS][1]) + r_tm[1]);
            o_word.point_z <= sat32(96'(r_c[4+QS][2]) + r_tm[2]);
            o_word.offset_x <= sat32(r_tm[0]);
            o_word.offset_y <= sat32(r_tm[1]);
            o_word.offset_z <= sat32(r_tm[2]);
        end
        o_word.status <= r_st[4+QS];
    end

    assign o_valid = r_v[NST];
endmodule

### src/closest_point_on_normal_line.sv
// Top level of the closest point on normal line block.
// Accepts one word per cycle (busy is always low). Each result is strobed for
// one cycle on o_done, after passing through 117 register stages in all: 65
// in each of the two normalisers running side by side (align, square sum, 32
// root stages, 31 divide stages) and 52 in the solver (products, sums,
// num/den and status, magnitudes, 46 quotient stages, terms, output).
// Results cannot be held off.
// Write epsilon through the cfg channel only while idle.
`include "assert_macros.svh"
module closest_point_on_normal_line import cpnl_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_done,
    output t_out_word o_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_eps;
    logic        acc;
    logic signed [32:0] nv [3], dv [3], dd [3];
    logic signed [31:0] u1 [3], u2 [3];
    logic v1, v2;
    logic [3*32+3*33-1:0] tag1, tag2;
    logic signed [31:0] cc [3];
    logic signed [32:0] dl [3];

    assign busy = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eps <= 16'd7;
        else if (i_cfg_valid && o_cfg_ready) r_eps <= i_cfg_data;
    end

    always_comb begin
        nv[0] = 33'(i_word.normal_x);
        nv[1] = 33'(i_word.normal_y);
        nv[2] = 33'(i_word.normal_z);
        dv[0] = 33'(i_word.far_x) - 33'(i_word.near_x);
        dv[1] = 33'(i_word.far_y) - 33'(i_word.near_y);
        dv[2] = 33'(i_word.far_z) - 33'(i_word.near_z);
        dd[0] = 33'(i_word.near_x) - 33'(i_word.center_x);
        dd[1] = 33'(i_word.near_y) - 33'(i_word.center_y);
        dd[2] = 33'(i_word.near_z) - 33'(i_word.center_z);
    end

    // carry centre and offset along with the normaliser
    assign tag1 = {i_word.center_x, i_word.center_y, i_word.center_z, dd[0], dd[1], dd[2]};

    cpnl_norm #(.TAGW($bits(tag1))) u_n1 (
        .i_clk, .i_rst_n, .i_valid(acc), .i_v(nv), .i_tag(tag1),
        .o_valid(v1), .o_u(u1), .o_tag(tag2));

    logic [0:0] t2u;
    cpnl_norm #(.TAGW(1)) u_n2 (
        .i_clk, .i_rst_n, .i_valid(acc), .i_v(dv), .i_tag(1'b0),
        .o_valid(v2), .o_u(u2), .o_tag(t2u));

    assign {cc[0], cc[1], cc[2], dl[0], dl[1], dl[2]} = tag2;

    cpnl_solve #(.FRAC_BITS(FRAC_BITS)) u_s (
        .i_clk, .i_rst_n, .i_valid(v1 & v2 & (t2u == 1'b0)), .i_u1(u1), .i_u2(u2),
        .i_c(cc), .i_d(dl), .i_eps(r_eps), .o_valid(o_done), .o_word(o_word));

    `ASSERT_IMPL(a_norm_lock, i_clk, i_rst_n, v1 == v2)
    `ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, !busy)
    `ASSERT_NEXT(a_eps_hold, i_clk, i_rst_n, !i_cfg_valid, $stable(r_eps))
endmodule
